// ===== rtl/core/first_match_prefix_lookup_core_defines.svh =====
// assertion macros for the first-match prefix lookup core
// no dependencies; taken in by the files that carry concurrent checks
`ifndef FIRST_MATCH_PREFIX_LOOKUP_CORE_DEFINES_SVH
`define FIRST_MATCH_PREFIX_LOOKUP_CORE_DEFINES_SVH

// check sampled on the rising clock edge, masked while reset is low
`define FMPL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on the rising clock edge, also active during reset
`define FMPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fmpl_pkg.sv =====
// shared types, codes and helper functions of the first-match prefix lookup core
// no dependencies
`timescale 1ns / 1ps

package fmpl_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned COUNT_W           = 7;
  localparam int unsigned INDEX_W           = 6;
  localparam int unsigned ADDR_W            = 128;
  localparam int unsigned TREE_RADIX_W      = 3;

  // word kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // address families
  localparam logic [1:0] FAM_UNSPEC = 2'd0;
  localparam logic [1:0] FAM_V4     = 2'd1;
  localparam logic [1:0] FAM_V6     = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_INVAL  = 2'd1;
  localparam logic [1:0] ST_FAMILY = 2'd2;

  localparam logic [7:0] V4_LEN_MAX = 8'd32;
  localparam logic [7:0] V6_LEN_MAX = 8'd128;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] entry_index;
    logic [63:0]        addr_high;
    logic [63:0]        addr_low;
    logic [7:0]         prefix_length;
    logic [1:0]         family;
  } fmpl_in_t;

  typedef struct packed {
    logic               match_found;
    logic [INDEX_W-1:0] match_index;
    logic [1:0]         status;
  } fmpl_out_t;

  // count and family checks of one lookup that do not need the priority search
  typedef struct packed {
    logic count_nz;
    logic lk_fam_ok;
    logic fam0_ok;
    logic fam_ne;
  } fmpl_chk_t;

  // number of radix-8 tree levels needed to cover n leaves, at least one
  function automatic int unsigned fmpl_levels(int unsigned n);
    int unsigned lv;
    int unsigned span;
    lv   = 1;
    span = 8;
    while (span < n) begin
      lv   = lv + 1;
      span = span * 8;
    end
    return lv;
  endfunction

endpackage

// ===== rtl/core/fmpl_table.sv =====
// prefix table storage and per-entry compare of the lookup core
// depends on fmpl_pkg
`timescale 1ns / 1ps

module fmpl_table #(
  parameter int unsigned TABLE_ENTRIES = fmpl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  fmpl_pkg::fmpl_in_t             in_i,
  input  logic [fmpl_pkg::COUNT_W-1:0]   count_i,
  output logic [TABLE_ENTRIES-1:0]       hit_o,
  output logic [TABLE_ENTRIES-1:0]       bad_o,
  output logic [TABLE_ENTRIES-1:0]       inval_o,
  output logic [1:0]                     fam0_o
);
  import fmpl_pkg::*;

  logic [ADDR_W-1:0] addr_q [TABLE_ENTRIES];
  logic [ADDR_W-1:0] mask_q [TABLE_ENTRIES];
  logic [1:0]        fam_q  [TABLE_ENTRIES];
  logic              dead_q [TABLE_ENTRIES];

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] wr_mask;
  logic              wr_dead;
  logic [ADDR_W-1:0] lk_addr;

  // mask and overlong flag are worked out once at write time
  assign wr_addr = {in_i.addr_high, in_i.addr_low};
  assign wr_mask = ~({ADDR_W{1'b1}} >> in_i.prefix_length);
  assign wr_dead = in_i.prefix_length >
                   ((in_i.family == FAM_V4) ? V4_LEN_MAX : V6_LEN_MAX);
  assign lk_addr = wr_addr;
  assign fam0_o  = fam_q[0];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
    logic sel;
    logic in_range;

    assign sel      = wr_en_i && (32'(in_i.entry_index) == 32'(i));
    assign in_range = 32'(count_i) > 32'(i);

    always_ff @(posedge clk_i) begin
      if (sel) begin
        addr_q[i] <= wr_addr;
        mask_q[i] <= wr_mask;
        fam_q[i]  <= in_i.family;
        dead_q[i] <= wr_dead;
      end
    end

    assign hit_o[i] = in_range && !dead_q[i] &&
                      (((lk_addr ^ addr_q[i]) & mask_q[i]) == '0);

    if (i == 0) begin : g_first
      assign bad_o[i]   = 1'b0;
      assign inval_o[i] = 1'b0;
    end else begin : g_later
      assign bad_o[i]   = in_range &&
                          ((fam_q[i] == FAM_UNSPEC) || (fam_q[i] != fam_q[0]));
      assign inval_o[i] = fam_q[i] == FAM_UNSPEC;
    end
  end

endmodule

// ===== rtl/core/fmpl_prio_tree.sv =====
// registered radix-8 priority encoder tree, one register level per tree level
// depends on fmpl_pkg
`timescale 1ns / 1ps

module fmpl_prio_tree #(
  parameter int unsigned WIDTH = fmpl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             en_i,
  input  logic [WIDTH-1:0]                                 req_i,
  input  logic [WIDTH-1:0]                                 flag_i,
  output logic                                             found_o,
  output logic [fmpl_pkg::TREE_RADIX_W*fmpl_pkg::fmpl_levels(WIDTH)-1:0] index_o,
  output logic                                             flag_o
);
  import fmpl_pkg::*;

  localparam int unsigned LEVELS = fmpl_levels(WIDTH);
  localparam int unsigned IW     = TREE_RADIX_W * LEVELS;
  localparam int unsigned PAD    = 1 << IW;

  logic [PAD-1:0] lf_vld;
  logic [PAD-1:0] lf_flg;

  logic [PAD-1:0] d_vld [LEVELS];
  logic [PAD-1:0] d_flg [LEVELS];
  logic [IW-1:0]  d_idx [LEVELS][PAD];
  logic [PAD-1:0] q_vld [LEVELS];
  logic [PAD-1:0] q_flg [LEVELS];
  logic [IW-1:0]  q_idx [LEVELS][PAD];

  assign lf_vld = PAD'(req_i);
  assign lf_flg = PAD'(flag_i);

  // each node keeps the lowest child with a request
  always_comb begin
    logic          sv;
    logic          sf;
    logic [IW-1:0] si;
    logic          cv;
    logic          cf;
    logic [IW-1:0] ci;
    int unsigned   c;
    d_vld = '{default: '0};
    d_flg = '{default: '0};
    d_idx = '{default: '0};
    for (int l = 0; l < LEVELS; l++) begin
      for (int n = 0; n < PAD; n++) begin
        if (n < (PAD >> (TREE_RADIX_W * (l + 1)))) begin
          sv = 1'b0;
          sf = 1'b0;
          si = '0;
          for (int k = 7; k >= 0; k--) begin
            c = n * 8 + k;
            if (l == 0) begin
              cv = lf_vld[c];
              cf = lf_flg[c];
              ci = '0;
            end else begin
              cv = q_vld[l-1][c];
              cf = q_flg[l-1][c];
              ci = q_idx[l-1][c];
            end
            if (cv) begin
              sv = 1'b1;
              sf = cf;
              si = ci | (IW'(k) << (TREE_RADIX_W * l));
            end
          end
          d_vld[l][n] = sv;
          d_flg[l][n] = sf;
          d_idx[l][n] = si;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_vld <= d_vld;
      q_flg <= d_flg;
      q_idx <= d_idx;
    end
  end

  assign found_o = q_vld[LEVELS-1][0];
  assign flag_o  = q_flg[LEVELS-1][0];
  assign index_o = q_idx[LEVELS-1][0];

endmodule

// ===== rtl/core/first_match_prefix_lookup_core.sv =====
// Top level of the first-match prefix lookup core.
// Depends on fmpl_pkg, fmpl_table, fmpl_prio_tree and the assertion macro header.
//
// Usage:
//   in channel (in_valid_i / in_stall_o / in_data_i): one word per accepted edge.
//     kind write loads table slot entry_index and gives no result; kind lookup
//     gives exactly one result word, in order.
//   out channel (out_valid_o / out_stall_i / out_data_o): match_found,
//     match_index and status of each lookup.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes entry_count;
//     always ready, to be written only while no lookup is in flight.
// Pipeline: out_valid_o rises once the word has passed the compare stage, the
//   tree levels and the result stage (two tree levels for 64 entries).
// Throughput: one word per cycle while no result is held; the compare stage and each
//   radix-8 tree level are registered, so a new word enters every unstalled cycle.
// Reset: clears entry_count and all pipeline valid bits; table slots hold
//   garbage until written.
// Stall: a held result freezes the whole pipeline and raises in_stall_o in
//   the same cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "first_match_prefix_lookup_core_defines.svh"

module first_match_prefix_lookup_core #(
  parameter int unsigned TABLE_ENTRIES = fmpl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fmpl_pkg::fmpl_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fmpl_pkg::fmpl_out_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fmpl_pkg::COUNT_W-1:0] cfg_data_i
);
  import fmpl_pkg::*;

  localparam int unsigned LEVELS = fmpl_levels(TABLE_ENTRIES);
  localparam int unsigned IW     = TREE_RADIX_W * LEVELS;

  // pipeline advance: everything moves unless a finished word is held
  logic adv;
  logic acc;
  logic wr_en;
  logic lk_acc;

  logic [COUNT_W-1:0] count_q;

  // per-entry compare results
  logic [TABLE_ENTRIES-1:0] hit;
  logic [TABLE_ENTRIES-1:0] bad;
  logic [TABLE_ENTRIES-1:0] inval;
  logic [1:0]               fam0;
  fmpl_chk_t                chk_d;

  // stage 1: compare vectors
  logic                     s1_valid_q;
  logic [TABLE_ENTRIES-1:0] s1_hit_q;
  logic [TABLE_ENTRIES-1:0] s1_bad_q;
  logic [TABLE_ENTRIES-1:0] s1_inval_q;
  fmpl_chk_t                s1_chk_q;

  // sideband that rides alongside the tree levels
  logic [LEVELS-1:0] sb_valid_q;
  fmpl_chk_t         sb_chk_q [LEVELS];

  // tree outputs
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic          bad_found;
  logic [IW-1:0] bad_idx;
  logic          bad_inval;
  logic [IW+INDEX_W-1:0] hit_idx_ext;

  // result stage
  fmpl_chk_t last_chk;
  fmpl_out_t res_d;
  fmpl_out_t res_q;
  logic      out_valid_q;

  assign adv         = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign acc         = in_valid_i && adv;
  assign wr_en       = acc && (in_data_i.kind == KIND_WRITE);
  assign lk_acc      = acc && (in_data_i.kind == KIND_LOOKUP);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  // table slots are written at the accept edge, so a lookup sees every
  // earlier write and none of the later ones
  fmpl_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .wr_en_i (wr_en),
    .in_i    (in_data_i),
    .count_i (count_q),
    .hit_o   (hit),
    .bad_o   (bad),
    .inval_o (inval),
    .fam0_o  (fam0)
  );

  // checks that need only the entry count, entry 0 and the lookup family
  always_comb begin
    chk_d.count_nz  = count_q != '0;
    chk_d.lk_fam_ok = (in_data_i.family == FAM_V4) || (in_data_i.family == FAM_V6);
    chk_d.fam0_ok   = (fam0 == FAM_V4) || (fam0 == FAM_V6);
    chk_d.fam_ne    = in_data_i.family != fam0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= lk_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_hit_q   <= hit;
      s1_bad_q   <= bad;
      s1_inval_q <= inval;
      s1_chk_q   <= chk_d;
    end
  end

  // first containing entry
  fmpl_prio_tree #(
    .WIDTH(TABLE_ENTRIES)
  ) u_hit_tree (
    .clk_i   (clk_i),
    .en_i    (adv),
    .req_i   (s1_hit_q),
    .flag_i  ('0),
    .found_o (hit_found),
    .index_o (hit_idx),
    .flag_o  ()
  );

  // first later entry with a family problem; the flag tells invalid from mismatch
  fmpl_prio_tree #(
    .WIDTH(TABLE_ENTRIES)
  ) u_bad_tree (
    .clk_i   (clk_i),
    .en_i    (adv),
    .req_i   (s1_bad_q),
    .flag_i  (s1_inval_q),
    .found_o (bad_found),
    .index_o (bad_idx),
    .flag_o  (bad_inval)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_valid_q <= '0;
    end else if (adv) begin
      for (int l = 0; l < LEVELS; l++) begin
        if (l == 0) begin
          sb_valid_q[l] <= s1_valid_q;
        end else begin
          sb_valid_q[l] <= sb_valid_q[l-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < LEVELS; l++) begin
        if (l == 0) begin
          sb_chk_q[l] <= s1_chk_q;
        end else begin
          sb_chk_q[l] <= sb_chk_q[l-1];
        end
      end
    end
  end

  assign last_chk    = sb_chk_q[LEVELS-1];
  assign hit_idx_ext = {{INDEX_W{1'b0}}, hit_idx};

  // status in the check order: empty table, lookup family, entry 0 family,
  // later entries, then lookup against entry 0
  always_comb begin
    res_d.status = ST_OK;
    if (!last_chk.count_nz) begin
      res_d.status = ST_OK;
    end else if (!last_chk.lk_fam_ok) begin
      res_d.status = ST_INVAL;
    end else if (!last_chk.fam0_ok) begin
      res_d.status = ST_INVAL;
    end else if (bad_found) begin
      res_d.status = bad_inval ? ST_INVAL : ST_FAMILY;
    end else if (last_chk.fam_ne) begin
      res_d.status = ST_FAMILY;
    end
    res_d.match_found = (res_d.status == ST_OK) && hit_found;
    res_d.match_index = res_d.match_found ? hit_idx_ext[INDEX_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sb_valid_q[LEVELS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  `FMPL_ASSERT(a_lookup_enters, clk_i, rst_ni, (in_valid_i && !in_stall_o && in_data_i.kind == KIND_LOOKUP) |=> s1_valid_q, "accepted lookup did not enter the compare stage")
  `FMPL_ASSERT(a_no_spurious_word, clk_i, rst_ni, (!in_stall_o && !(in_valid_i && in_data_i.kind == KIND_LOOKUP)) |=> !s1_valid_q, "compare stage valid without an accepted lookup")
  `FMPL_ASSERT(a_error_clears_match, clk_i, rst_ni, (out_valid_o && out_data_o.status != ST_OK) |-> (!out_data_o.match_found && out_data_o.match_index == '0), "match reported with error status")
  `FMPL_ASSERT(a_index_in_table, clk_i, rst_ni, (out_valid_o && out_data_o.match_found) |-> (32'(out_data_o.match_index) < TABLE_ENTRIES), "match index beyond the table")
  `FMPL_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result word after reset")

endmodule
